### rtl/bgd_pkg.sv
// Package: shared types, codes and constants of the button gesture detector
package bgd_pkg;

   localparam int TICK_WIDTH = 16;
   localparam int LIMIT_WIDTH = 16;
   localparam int CMP_WIDTH = (TICK_WIDTH > LIMIT_WIDTH) ? TICK_WIDTH : LIMIT_WIDTH;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [3:0] REPEAT_MAX = 4'd15;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_PRESSED  = 3'd1,
      PH_RELEASED = 3'd2,
      PH_AGAIN    = 3'd3,
      PH_LONG     = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_DOWN       = 3'd1,
      EV_UP         = 3'd2,
      EV_SINGLE     = 3'd3,
      EV_DOUBLE     = 3'd4,
      EV_LONG_START = 3'd5,
      EV_LONG_HOLD  = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      REG_PRESS_LEVEL    = 2'd0,
      REG_DEBOUNCE_COUNT = 2'd1,
      REG_SHORT_LIMIT    = 2'd2,
      REG_LONG_LIMIT     = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic                   press_level;
      logic [2:0]             debounce_count;
      logic [LIMIT_WIDTH-1:0] short_limit;
      logic [LIMIT_WIDTH-1:0] long_limit;
   } cfg_type;

endpackage

### rtl/bgd_debounce.sv
// Debounce filter: accepts a new level after enough consecutive differing ticks
module bgd_debounce (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       raw,
   input  logic [2:0] debounce_count,
   output logic       stable_level
);
   import bgd_pkg::*;

   logic       stable_ff, stable_in;
   logic [2:0] bounce_ff, bounce_in;
   logic [2:0] bounce_inc;

   // Count differing ticks; take the raw level once the count is reached
   always_comb begin
      bounce_inc = bounce_ff + 3'd1;
      stable_in  = stable_ff;
      bounce_in  = 3'd0;
      if (raw != stable_ff) begin
         if (bounce_inc >= debounce_count) begin
            stable_in = raw;
         end else begin
            bounce_in = bounce_inc;
         end
      end
   end

   // Advance the filter once per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 1'b0;
         bounce_ff <= 3'd0;
      end else if (step) begin
         stable_ff <= stable_in;
         bounce_ff <= bounce_in;
      end
   end

   assign stable_level = stable_in;

endmodule

### rtl/bgd_phase.sv
// Gesture phase machine with tick counter, repeat count and event register
module bgd_phase (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               pressed,
   input  bgd_pkg::cfg_type   cfg,
   output bgd_pkg::event_type event_next,
   output logic [3:0]         repeats_next
);
   import bgd_pkg::*;

   phase_type             phase_ff, phase_in;
   event_type             event_ff, event_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in, tick_inc;
   logic [3:0]            repeats_ff, repeats_in;
   logic [CMP_WIDTH-1:0]  tick_ext, short_ext, long_ext;
   logic                  over_short, under_short, over_long;

   // Advance the tick counter outside idle, then compare against the limits
   always_comb begin
      tick_inc    = (phase_ff != PH_IDLE) ? tick_ff + TICK_WIDTH'(1) : tick_ff;
      tick_ext    = CMP_WIDTH'(tick_inc);
      short_ext   = CMP_WIDTH'(cfg.short_limit);
      long_ext    = CMP_WIDTH'(cfg.long_limit);
      over_short  = tick_ext > short_ext;
      under_short = tick_ext < short_ext;
      over_long   = tick_ext > long_ext;
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (pressed) phase_in = PH_PRESSED;
         end
         PH_PRESSED: begin
            if (!pressed) phase_in = PH_RELEASED;
            else if (over_long) phase_in = PH_LONG;
         end
         PH_RELEASED: begin
            if (pressed) phase_in = PH_AGAIN;
            else if (over_short) phase_in = PH_IDLE;
         end
         PH_AGAIN: begin
            if (!pressed) phase_in = under_short ? PH_RELEASED : PH_IDLE;
            else if (over_short) phase_in = PH_PRESSED;
         end
         PH_LONG: begin
            if (!pressed) phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // Event, tick counter and repeat count
   always_comb begin
      event_in   = event_ff;
      tick_in    = tick_inc;
      repeats_in = repeats_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (pressed) begin
               event_in   = EV_DOWN;
               tick_in    = '0;
               repeats_in = 4'd1;
            end else begin
               event_in = EV_NONE;
            end
         end
         PH_PRESSED: begin
            if (!pressed) begin
               event_in = EV_UP;
               tick_in  = '0;
            end else if (over_long) begin
               event_in = EV_LONG_START;
            end
         end
         PH_RELEASED: begin
            if (pressed) begin
               event_in = EV_DOWN;
               tick_in  = '0;
               if (repeats_ff != REPEAT_MAX) repeats_in = repeats_ff + 4'd1;
            end else if (over_short) begin
               if (repeats_ff == 4'd1) event_in = EV_SINGLE;
               else if (repeats_ff == 4'd2) event_in = EV_DOUBLE;
            end
         end
         PH_AGAIN: begin
            if (!pressed) begin
               event_in = EV_UP;
               if (under_short) tick_in = '0;
            end
         end
         PH_LONG: begin
            event_in = pressed ? EV_LONG_HOLD : EV_UP;
         end
         default: ;
      endcase
   end

   // Hold state between transfers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         event_ff   <= EV_NONE;
         tick_ff    <= '0;
         repeats_ff <= 4'd0;
      end else if (step) begin
         phase_ff   <= phase_in;
         event_ff   <= event_in;
         tick_ff    <= tick_in;
         repeats_ff <= repeats_in;
      end
   end

   assign event_next   = event_in;
   assign repeats_next = repeats_in;

   // A click sequence in progress has seen at least one press
   a_repeats_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> repeats_ff != 4'd0)
      else $error("repeat count zero outside idle");

   // Long press events only stand while the long hold phase is held
   a_long_event: assert property (@(posedge clock) disable iff (reset)
      (event_ff == EV_LONG_START || event_ff == EV_LONG_HOLD) |-> phase_ff == PH_LONG)
      else $error("long press event outside long hold");

   // State moves only on a transfer
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(tick_ff) && $stable(repeats_ff))
      else $error("phase state changed without transfer");

endmodule

### rtl/button_gesture_detector.sv
// Top level: input register, gesture logic, result register and CSR block
// Flow: an item passes the input register, then the result register, where its result
//   waits until it transfers; one result per item.
// Throughput: one item per cycle while rsp_ready is high; the result register and input
//   register let a new item enter while a finished result waits.
// Reset (synchronous): filter, phase, counters and event return to zero/idle and
//   the registers take press level 1, debounce_count 3, short 60, long 200.
module button_gesture_detector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_raw_active,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_event_code,
   output logic [3:0]                          rsp_repeat_count,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bgd_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [bgd_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [bgd_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready
);
   import bgd_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_index;
   logic          csr_write;

   logic       in_valid_ff, in_valid_in;
   logic       raw_ff;
   logic       step;
   logic       stable_level;
   logic       pressed;
   event_type  event_next;
   logic [3:0] repeats_next;
   logic       out_valid_ff, out_valid_in;
   logic [2:0] event_ff;
   logic [3:0] repeats_ff;

   // Register file writes
   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_PRESS_LEVEL:    cfg_in.press_level    = pwdata[0];
            REG_DEBOUNCE_COUNT: cfg_in.debounce_count = pwdata[2:0];
            REG_SHORT_LIMIT:    cfg_in.short_limit    = pwdata[LIMIT_WIDTH-1:0];
            REG_LONG_LIMIT:     cfg_in.long_limit     = pwdata[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Register file reads
   always_comb begin
      unique case (reg_index)
         REG_PRESS_LEVEL:    prdata = CSR_DATA_WIDTH'(cfg_ff.press_level);
         REG_DEBOUNCE_COUNT: prdata = CSR_DATA_WIDTH'(cfg_ff.debounce_count);
         REG_SHORT_LIMIT:    prdata = CSR_DATA_WIDTH'(cfg_ff.short_limit);
         REG_LONG_LIMIT:     prdata = CSR_DATA_WIDTH'(cfg_ff.long_limit);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_level    <= 1'b1;
         cfg_ff.debounce_count <= 3'd3;
         cfg_ff.short_limit    <= LIMIT_WIDTH'(60);
         cfg_ff.long_limit     <= LIMIT_WIDTH'(200);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Process the held item when the result register is free or drains
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   // Input register: take a transfer, drop the item once processed
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) raw_ff <= req_raw_active;
   end

   bgd_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .raw            (raw_ff),
      .debounce_count (cfg_ff.debounce_count),
      .stable_level   (stable_level)
   );

   assign pressed = (stable_level == cfg_ff.press_level);

   bgd_phase u_phase (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .pressed      (pressed),
      .cfg          (cfg_ff),
      .event_next   (event_next),
      .repeats_next (repeats_next)
   );

   // Result register: load on a step, drop after the transfer
   always_comb begin
      out_valid_in = out_valid_ff;
      if (step) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (step) begin
         event_ff   <= event_next;
         repeats_ff <= repeats_next;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_code   = event_ff;
   assign rsp_repeat_count = repeats_ff;

endmodule

### test/button_gesture_detector_tb.sv
// Testbench of the button gesture detector: directed gestures, random settings, back-pressure
`timescale 1ns / 100ps

module button_gesture_detector_tb;
   import bgd_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int SPAN_CAP    = 70;
   localparam int REPORT_MAX  = 40;

   typedef struct {
      event_type  ev;
      logic [3:0] repeats;
   } gesture_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_raw_active = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [2:0]                rsp_event_code;
   logic [3:0]                rsp_repeat_count;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   // predicted detector state and register copy
   cfg_type               cfg;
   logic                  flt_level;
   logic [2:0]            flt_count;
   phase_type             gest_phase;
   logic [TICK_WIDTH-1:0] hold_ticks;
   logic [3:0]            press_total;
   event_type             gest_event;

   gesture_type pending_gestures[$];
   gesture_type due_gesture;
   int          mismatch_count = 0;
   int          ticks_sent = 0;
   int          quiet_cycles = 0;
   int          rsp_hold_request = 0;
   int          rsp_stall_left = 0;
   bit          idle_enabled = 1'b1;

   button_gesture_detector dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_raw_active   (req_raw_active),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_code   (rsp_event_code),
      .rsp_repeat_count (rsp_repeat_count),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Advance the predicted debounce filter and phase machine by one tick
   function automatic void step_gesture(input logic raw);
      logic        pressed;
      gesture_type outcome;
      if (gest_phase != PH_IDLE) hold_ticks = hold_ticks + TICK_WIDTH'(1);
      if (raw != flt_level) begin
         flt_count = flt_count + 3'd1;
         if (flt_count >= cfg.debounce_count) begin
            flt_level = raw;
            flt_count = '0;
         end
      end else begin
         flt_count = '0;
      end
      pressed = (flt_level == cfg.press_level);
      case (gest_phase)
         PH_IDLE: begin
            if (pressed) begin
               gest_event  = EV_DOWN;
               hold_ticks  = '0;
               press_total = 4'd1;
               gest_phase  = PH_PRESSED;
            end else begin
               gest_event = EV_NONE;
            end
         end
         PH_PRESSED: begin
            if (!pressed) begin
               gest_event = EV_UP;
               hold_ticks = '0;
               gest_phase = PH_RELEASED;
            end else if (hold_ticks > cfg.long_limit) begin
               gest_event = EV_LONG_START;
               gest_phase = PH_LONG;
            end
         end
         PH_RELEASED: begin
            if (pressed) begin
               gest_event = EV_DOWN;
               if (press_total != REPEAT_MAX) press_total = press_total + 4'd1;
               hold_ticks = '0;
               gest_phase = PH_AGAIN;
            end else if (hold_ticks > cfg.short_limit) begin
               // three or more presses time out without a new event
               if (press_total == 4'd1) gest_event = EV_SINGLE;
               else if (press_total == 4'd2) gest_event = EV_DOUBLE;
               gest_phase = PH_IDLE;
            end
         end
         PH_AGAIN: begin
            if (!pressed) begin
               gest_event = EV_UP;
               if (hold_ticks < cfg.short_limit) begin
                  hold_ticks = '0;
                  gest_phase = PH_RELEASED;
               end else begin
                  gest_phase = PH_IDLE;
               end
            end else if (hold_ticks > cfg.short_limit) begin
               gest_phase = PH_PRESSED;
            end
         end
         PH_LONG: begin
            if (pressed) begin
               gest_event = EV_LONG_HOLD;
            end else begin
               gest_event = EV_UP;
               gest_phase = PH_IDLE;
            end
         end
         default: gest_phase = PH_IDLE;
      endcase
      outcome.ev      = gest_event;
      outcome.repeats = press_total;
      pending_gestures.push_back(outcome);
   endfunction

   // Offer one tick sample, with an occasional idle burst first; valid stays high afterwards
   task automatic send_tick(input logic raw);
      if (idle_enabled && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_raw_active <= raw;
      do @(posedge clock); while (!req_ready);
      step_gesture(raw);
      ticks_sent++;
   endtask

   task automatic send_run(input logic raw, input int count);
      for (int i = 0; i < count; i++) send_tick(raw);
   endtask

   // Send a directed pattern, most significant bit first
   task automatic send_bits(input logic [63:0] pattern, input int count);
      for (int i = count - 1; i >= 0; i--) send_tick(pattern[i]);
   endtask

   task automatic send_noise(input int count);
      for (int i = 0; i < count; i++) send_tick(1'($urandom_range(0, 1)));
   endtask

   // Drop valid and hold until every predicted result has been checked
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_gestures.size() != 0);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the access edge
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_PRESS_LEVEL:    cfg.press_level    = value[0];
         REG_DEBOUNCE_COUNT: cfg.debounce_count = value[2:0];
         REG_SHORT_LIMIT:    cfg.short_limit    = value[LIMIT_WIDTH-1:0];
         REG_LONG_LIMIT:     cfg.long_limit     = value[LIMIT_WIDTH-1:0];
         default: ;
      endcase
      // hold the bus idle between writes
      @(posedge clock);
   endtask

   task automatic configure(input logic active, input int debounce, input int short_lim,
                            input int long_lim);
      pause_until_drained();
      csr_write(REG_PRESS_LEVEL, {31'd0, active});
      csr_write(REG_DEBOUNCE_COUNT, debounce);
      csr_write(REG_SHORT_LIMIT, short_lim);
      csr_write(REG_LONG_LIMIT, long_lim);
   endtask

   // Tick count around a limit, capped so that huge limits stay cheap
   function automatic int near(input int limit, input int spread);
      int span;
      span = limit + $urandom_range(0, 2 * spread) - spread;
      if (span < 0) span = 0;
      if (span > SPAN_CAP) span = SPAN_CAP;
      return span;
   endfunction

   function automatic int pick_span(input bit with_long);
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 3);
         1: return near(int'(cfg.short_limit), 2);
         2: return with_long ? near(int'(cfg.long_limit), 2) : $urandom_range(0, 6);
         default: return $urandom_range(0, 12);
      endcase
   endfunction

   // Press and release a number of times, with some bounce, then wait for the timeout
   task automatic play_gesture(input int presses);
      logic on_lvl;
      int   need;
      on_lvl = cfg.press_level;
      need   = (cfg.debounce_count == 0) ? 1 : int'(cfg.debounce_count);
      for (int p = 0; p < presses; p++) begin
         if (need > 1 && $urandom_range(0, 3) == 0) begin
            send_run(on_lvl, $urandom_range(1, need - 1));
            send_tick(!on_lvl);
         end
         send_run(on_lvl, need + pick_span(1'b1));
         send_run(!on_lvl, need + pick_span(1'b0));
      end
      send_run(!on_lvl, near(int'(cfg.short_limit) + 3, 1));
   endtask

   task automatic run_random_segment(input int quota);
      int start;
      start = ticks_sent;
      while (ticks_sent - start < quota) begin
         case ($urandom_range(0, 9))
            0, 1: send_noise($urandom_range(1, 12));
            2, 3: play_gesture($urandom_range(4, 18));
            default: play_gesture($urandom_range(1, 3));
         endcase
      end
   endtask

   task automatic test_zero_debounce();
      configure(1'b1, 0, 2, 3);
      send_bits(64'b100000, 6);
      send_bits(64'b10100000, 8);
      send_bits(64'b111111100, 9);
   endtask

   task automatic test_triple_timeout();
      send_bits(64'b1010100000, 10);
   endtask

   // Slowest filter, zero limits and a low press level: pressed straight out of idle
   task automatic test_debounce_extremes();
      configure(1'b0, 7, 0, 0);
      send_bits(64'b111001111111100000000, 21);
   endtask

   // Hold the second press past the repeat window into a long press, then release
   task automatic test_long_hold();
      configure(1'b1, 1, 40, 100);
      idle_enabled = 1'b0;
      send_bits(64'b1100, 4);
      send_run(1'b1, 110);
      send_bits(64'b001100, 6);
      idle_enabled = 1'b1;
   endtask

   // Stall results for a long stretch while ticks keep coming, then pause until drained
   task automatic test_backpressure();
      configure(1'b1, 2, 4, 9);
      rsp_hold_request = 90;
      send_noise(30);
      play_gesture(2);
      pause_until_drained();
   endtask

   task automatic test_random_settings();
      configure(1'b1, 3, 60, 200);
      run_random_segment(150);
      configure(1'b0, 1, 5, 12);
      run_random_segment(120);
      configure(1'b1, 7, 20, 40);
      run_random_segment(120);
      configure(1'b1, 0, 0, 0);
      run_random_segment(120);
      configure(1'b0, 2, 65535, 65535);
      run_random_segment(40);
      repeat (2) begin
         configure(1'($urandom_range(0, 1)), $urandom_range(0, 7), $urandom_range(0, 30),
                   $urandom_range(0, 60));
         run_random_segment(120);
      end
      // last part runs without any idling
      configure(1'($urandom_range(0, 1)), $urandom_range(0, 7), $urandom_range(0, 30),
                $urandom_range(0, 60));
      idle_enabled = 1'b0;
      run_random_segment(120);
   endtask

   // Check each result transfer and choose the next ready, with random stall bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_gestures.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: unexpected result, actual event %0d repeats %0d",
                        $time, rsp_event_code, rsp_repeat_count);
         end else begin
            due_gesture = pending_gestures.pop_front();
            if (rsp_event_code !== due_gesture.ev) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: event_code expected %0d, actual %0d",
                           $time, due_gesture.ev, rsp_event_code);
            end
            if (rsp_repeat_count !== due_gesture.repeats) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: repeat_count expected %0d, actual %0d",
                           $time, due_gesture.repeats, rsp_repeat_count);
            end
         end
      end
      if (rsp_hold_request != 0) begin
         rsp_stall_left   = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
         rsp_stall_left = $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // End the run when no transfer of any kind happens for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      cfg         = {1'b1, 3'd3, 16'd60, 16'd200};
      flt_level   = 1'b0;
      flt_count   = '0;
      gest_phase  = PH_IDLE;
      hold_ticks  = '0;
      press_total = '0;
      gest_event  = EV_NONE;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_zero_debounce();
      test_triple_timeout();
      test_debounce_extremes();
      test_long_hold();
      test_backpressure();
      test_random_settings();
      pause_until_drained();
      repeat (8) @(posedge clock);
      if (pending_gestures.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d results never arrived", $time, pending_gestures.size());
      end
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
